// ----- rtl/sapd_pkg.sv -----
`default_nettype none
// Shared types and constants for the sonar approach speed controller.
// No dependencies; imported by every module of the block.
package sapd_pkg;

  localparam int unsigned DIST_W  = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DIFF_W  = 18;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned NUM_W   = 27;
  localparam int unsigned MAG_W   = 26;
  localparam int unsigned QUO_W   = 24;
  localparam int unsigned FIX_W   = 24;
  localparam int unsigned OPA_W   = 24;
  localparam int unsigned OPB_W   = 16;
  localparam int unsigned PROD_W  = 40;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned IDX_W   = 3;

  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd24;
  localparam logic [QUO_W-1:0] DEADBAND  = 24'd3276;
  localparam logic [FIX_W-1:0] FIX_POS   = 24'h7fffff;
  localparam logic [FIX_W-1:0] FIX_NEG   = 24'h800000;

  localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd2;
  localparam logic [IDX_W-1:0] REG_TOLERANCE = 3'd3;
  localparam logic [IDX_W-1:0] REG_ACQ_RANGE = 3'd4;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- rtl/sapd_mul.sv -----
`default_nettype none
// Registered signed multiplier shared by the gain and speed scaling steps.
// Depends on sapd_pkg for operand and product widths.
module sapd_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [sapd_pkg::OPA_W-1:0]   a_i,
  input  wire logic signed [sapd_pkg::OPB_W-1:0]   b_i,
  output logic signed [sapd_pkg::PROD_W-1:0]       p_o
);
  import sapd_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ----- rtl/sapd_div.sv -----
`default_nettype none
// Serial restoring divider producing a 24-bit Q16 fraction magnitude, one bit per cycle.
// Depends on sapd_pkg for widths, step count and the status struct.
module sapd_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sapd_pkg::MAG_W-1:0]    dividend_i,
  input  wire logic [sapd_pkg::DIST_W-1:0]   divisor_i,
  output logic [sapd_pkg::QUO_W-1:0]         quot_o,
  output sapd_pkg::div_stat_t                stat_o
);
  import sapd_pkg::*;

  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic              ovf_q;
  logic [DIST_W-1:0] rem_q;
  logic [DIST_W-1:0] den_q;
  logic [QUO_W-1:0]  dvd_q;
  logic [DIST_W:0]   rem_sh;
  logic [DIST_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[QUO_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_STEPS;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= dividend_i[MAG_W-1:8] >= {2'b00, divisor_i};
      rem_q <= dividend_i[DIST_W+7:8];
      dvd_q <= {dividend_i[7:0], 16'd0};
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rem_sub[DIST_W-1:0] : rem_sh[DIST_W-1:0];
      dvd_q <= {dvd_q[QUO_W-2:0], ge};
    end
  end

  assign quot_o      = dvd_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule
`default_nettype wire

// ----- rtl/sonar_pd_approach_speed_core.sv -----
`default_nettype none
// Sonar approach speed controller: a PD controller normalized by a distance.
// One item at a time: an item passes the prepare, multiply, sum, 24-step
// serial divide and scale states, or goes straight to done when no division
// is needed; input ready returns as the result turns valid. Reset restores
// the register defaults, arms acquire and clears the reference range and
// previous error. Depends on sapd_pkg, sapd_mul and sapd_div.
module sonar_pd_approach_speed_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  kind_i,
  input  wire logic [sapd_pkg::DIST_W-1:0]           raw_distance_i,
  input  wire logic [sapd_pkg::DIST_W-1:0]           target_distance_i,
  input  wire logic signed [sapd_pkg::SPEED_W-1:0]   max_speed_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [sapd_pkg::SPEED_W-1:0]        speed_o,
  output logic                                       acquiring_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [sapd_pkg::IDX_W-1:0]            cfg_index_i,
  input  wire logic [sapd_pkg::DIST_W-1:0]           cfg_data_i
);
  import sapd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_P,
    S_MUL_D,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_S,
    S_SCALE,
    S_DONE
  } state_e;

  state_e state_q;

  logic [GAIN_W-1:0] gain_p_q;
  logic [GAIN_W-1:0] gain_d_q;
  logic [DIST_W-1:0] offset_q;
  logic [DIST_W-1:0] tol_q;
  logic [DIST_W-1:0] acq_range_q;

  logic              acq_q;
  logic [DIST_W-1:0] ref_q;
  logic [ERR_W-1:0]  prev_q;
  logic              out_valid_q;
  logic [SPEED_W-1:0] speed_q;
  logic              acq_out_q;

  logic               kind_q;
  logic [DIST_W-1:0]  raw_q;
  logic [DIST_W-1:0]  tgt_q;
  logic [SPEED_W-1:0] mspd_q;
  logic [ERR_W-1:0]   err_q;
  logic [DIFF_W-1:0]  diff_q;
  logic [DIST_W-1:0]  den_q;
  logic [NUM_W-1:0]   num_q;
  logic [FIX_W-1:0]   fix_q;
  logic [SPEED_W-1:0] res_q;

  logic [DIST_W:0]    lim;
  logic [DIST_W-1:0]  dcorr;
  logic [ERR_W-1:0]   err_c;
  logic [DIFF_W-1:0]  diff_c;
  logic               no_tgt;
  logic [DIST_W-1:0]  den_c;
  logic               zero_den;
  logic [NUM_W-1:0]   num_abs;
  logic               div_start;
  logic [QUO_W-1:0]   quot;
  div_stat_t          div_stat;
  logic               big;
  logic               in_db;
  logic [FIX_W-1:0]   fix_c;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]  tr;
  logic               fits;
  logic [SPEED_W-1:0] sat;
  logic               in_xfer;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign speed_o     = speed_q;
  assign acquiring_o = acq_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= 8'd1;
      gain_d_q    <= 8'd0;
      offset_q    <= 16'd0;
      tol_q       <= 16'd16;
      acq_range_q <= 16'd800;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAIN_P:    gain_p_q    <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_q    <= cfg_data_i[GAIN_W-1:0];
        REG_OFFSET:    offset_q    <= cfg_data_i;
        REG_TOLERANCE: tol_q       <= cfg_data_i;
        REG_ACQ_RANGE: acq_range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    lim      = {1'b0, offset_q} + {1'b0, tol_q};
    dcorr    = ({1'b0, raw_q} < lim) ? '0 : raw_q - offset_q;
    err_c    = {1'b0, dcorr} - {1'b0, tgt_q};
    diff_c   = {err_c[ERR_W-1], err_c} - {prev_q[ERR_W-1], prev_q};
    no_tgt   = !kind_q && acq_q && (dcorr > acq_range_q);
    den_c    = kind_q ? tgt_q : (acq_q ? dcorr : ref_q);
    zero_den = (den_c == '0);
    num_abs  = num_q[NUM_W-1] ? (NUM_W'(0) - num_q) : num_q;
  end

  always_comb begin
    big   = div_stat.ovf || quot[QUO_W-1];
    in_db = !kind_q && !big && (quot <= DEADBAND);
    if (in_db) begin
      fix_c = '0;
    end else if (big) begin
      fix_c = num_q[NUM_W-1] ? FIX_NEG : FIX_POS;
    end else begin
      fix_c = num_q[NUM_W-1] ? (FIX_W'(0) - quot) : quot;
    end
  end

  always_comb begin
    case (state_q)
      S_MUL_P: begin
        mul_a = {{(OPA_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mul_b = {{(OPB_W-GAIN_W){gain_p_q[GAIN_W-1]}}, gain_p_q};
      end
      S_MUL_D: begin
        mul_a = {{(OPA_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
        mul_b = {{(OPB_W-GAIN_W){gain_d_q[GAIN_W-1]}}, gain_d_q};
      end
      default: begin
        mul_a = fix_q;
        mul_b = mspd_q;
      end
    endcase
  end

  always_comb begin
    tr   = prod + (prod[PROD_W-1] ? 40'd65535 : 40'd0);
    fits = (&tr[PROD_W-1:31]) || !(|tr[PROD_W-1:31]);
    sat  = fits ? tr[31:16] : (tr[PROD_W-1] ? 16'h8000 : 16'h7fff);
  end

  assign div_start = (state_q == S_DIV_GO);

  sapd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  sapd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_abs[MAG_W-1:0]),
    .divisor_i  (den_q),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acq_q       <= 1'b1;
      ref_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      speed_q     <= '0;
      acq_out_q   <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (!kind_q && acq_q) begin
            ref_q <= dcorr;
            if (!no_tgt) begin
              acq_q <= 1'b0;
            end
          end
          if (!no_tgt) begin
            prev_q <= err_c;
          end
          state_q <= (no_tgt || zero_den) ? S_DONE : S_MUL_P;
        end
        S_MUL_P:  state_q <= S_MUL_D;
        S_MUL_D:  state_q <= S_SUM;
        S_SUM:    state_q <= S_DIV_GO;
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            if (in_db) begin
              acq_q <= 1'b1;
            end
            state_q <= S_MUL_S;
          end
        end
        S_MUL_S: state_q <= S_SCALE;
        S_SCALE: state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            speed_q     <= res_q;
            acq_out_q   <= acq_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= kind_i;
      raw_q  <= raw_distance_i;
      tgt_q  <= target_distance_i;
      mspd_q <= max_speed_i;
    end
    case (state_q)
      S_PREP: begin
        err_q  <= err_c;
        diff_q <= diff_c;
        den_q  <= den_c;
        res_q  <= no_tgt ? mspd_q : '0;
      end
      S_MUL_D: num_q <= prod[NUM_W-1:0];
      S_SUM:   num_q <= num_q + prod[NUM_W-1:0];
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          fix_q <= fix_c;
        end
      end
      S_SCALE: res_q <= sat;
      default: ;
    endcase
  end

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_deadband_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_S && !kind_q && acq_q) |-> (fix_q == '0))
    else $error("deadband re-armed acquire with a nonzero fraction");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || out_ready_i)) |=> out_valid_o)
    else $error("finished result was not presented");

endmodule
`default_nettype wire
